@@ hw/rtl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, codes and defaults of the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // field widths
  localparam int DATA_W    = 32;
  localparam int UCFG_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int SETTLE_W  = 8;
  localparam int VEL_W     = DATA_W + 1;

  // parameter defaults
  localparam int ANGLE_MODE_DEF  = 0;
  localparam int MIN_SETTLE_DEF  = 10;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // angle mode codes
  localparam int ANGLE_NONE = 0;
  localparam int ANGLE_DEG  = 1;
  localparam int ANGLE_RAD  = 2;

  // pi and two pi in Q2.30
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  // integral step cap after reset, 1.0 in Q16.16
  localparam logic [UCFG_W-1:0] STEP_CAP_RESET = 31'd65536;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_CLR_INT = 2'd1,
    OP_CLR_ALL = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_GAIN_FF     = 3'd3,
    REG_ERROR_BAND  = 3'd4,
    REG_STEP_CAP    = 3'd5,
    REG_OUT_CEILING = 3'd6,
    REG_OUT_FLOOR   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] gain_ff;
    logic [UCFG_W-1:0]        error_band;
    logic [UCFG_W-1:0]        integral_step_cap;
    logic [UCFG_W-1:0]        output_ceiling;
    logic [UCFG_W-1:0]        output_floor;
  } cfg_t;

  // one classified sample handed from front to back
  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] sp;
    logic signed [VEL_W-1:0]  vel;
    logic signed [DATA_W-1:0] isum;
    logic                     done;
  } job_t;

endpackage

@@ hw/rtl/pidc_if.sv @@
// ----------------------------------------------------------------------------
// pidc_if
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface pidc_sample_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [pidc_pkg::DATA_W-1:0] measured;
  logic signed [pidc_pkg::DATA_W-1:0] setpoint;

  modport source (output valid, opcode, measured, setpoint, input ready);
  modport sink   (input valid, opcode, measured, setpoint, output ready);
endinterface

interface pidc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [pidc_pkg::DATA_W-1:0] drive;
  logic signed [pidc_pkg::DATA_W-1:0] error_value;
  logic                              settled;

  modport source (output valid, drive, error_value, settled, input ready);
  modport sink   (input valid, drive, error_value, settled, output ready);
endinterface

@@ hw/rtl/pidc_front.sv @@
// ----------------------------------------------------------------------------
// pidc_front
// Accepts sample beats, wraps and classifies the error, updates the
// controller state and pushes one job per sample into the queue.
// ----------------------------------------------------------------------------
module pidc_front #(
  parameter int ANGLE_MODE         = pidc_pkg::ANGLE_MODE_DEF,
  parameter int MIN_SETTLE_SAMPLES = pidc_pkg::MIN_SETTLE_DEF,
  parameter int FRAC_BITS          = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  pidc_sample_if.sink      sample,
  input  pidc_pkg::cfg_t   cfg,
  output logic             push,
  output pidc_pkg::job_t   push_job,
  input  logic             full
);

  localparam int DW     = pidc_pkg::DATA_W;
  localparam int WRAP_W = 36;
  localparam int CMP_W  = DW + 2;
  localparam int SH     = 30 - FRAC_BITS;

  localparam longint HALF_DEG = longint'(180) << FRAC_BITS;
  localparam longint FULL_DEG = longint'(360) << FRAC_BITS;
  localparam longint HALF_RAD = (pidc_pkg::PI_Q30 + (longint'(1) << (SH - 1))) >>> SH;
  localparam longint FULL_RAD = (pidc_pkg::TWO_PI_Q30 + (longint'(1) << (SH - 1))) >>> SH;

  localparam logic WRAP_ON = (ANGLE_MODE == pidc_pkg::ANGLE_DEG) ||
                             (ANGLE_MODE == pidc_pkg::ANGLE_RAD);
  localparam logic signed [WRAP_W-1:0] HALF_TURN =
    WRAP_W'((ANGLE_MODE == pidc_pkg::ANGLE_DEG) ? HALF_DEG : HALF_RAD);
  localparam logic signed [WRAP_W-1:0] FULL_TURN =
    WRAP_W'((ANGLE_MODE == pidc_pkg::ANGLE_DEG) ? FULL_DEG : FULL_RAD);
  localparam logic signed [WRAP_W-1:0] S32_MAX = WRAP_W'(64'sd2147483647);
  localparam logic signed [WRAP_W-1:0] S32_MIN = -S32_MAX - WRAP_W'(1);

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_POS  = 2'd1,
    CLS_NEG  = 2'd2
  } err_cls_t;

  // one correction by a full turn
  function automatic logic signed [WRAP_W-1:0] wrap_angle(
    input logic signed [WRAP_W-1:0] x
  );
    logic signed [WRAP_W-1:0] y;
    y = x;
    if (WRAP_ON) begin
      if (x > HALF_TURN) y = x - FULL_TURN;
      else if (x < -HALF_TURN) y = x + FULL_TURN;
    end
    return y;
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [WRAP_W-1:0] x);
    logic signed [DW-1:0] y;
    if (x > S32_MAX) y = S32_MAX[DW-1:0];
    else if (x < S32_MIN) y = S32_MIN[DW-1:0];
    else y = x[DW-1:0];
    return y;
  endfunction

  // stage 1 registers
  logic                 f1_valid;
  logic [1:0]           f1_op;
  logic signed [DW-1:0] f1_meas;
  logic signed [DW-1:0] f1_sp;

  // stage 2 registers
  logic                 f2_valid;
  logic [1:0]           f2_op;
  logic signed [DW-1:0] f2_meas;
  logic signed [DW-1:0] f2_sp;
  logic signed [DW-1:0] f2_err;
  logic signed [DW-1:0] f2_step;
  err_cls_t             f2_cls;
  logic                 f2_near;

  // controller state
  logic signed [DW-1:0]               isum, isum_next;
  logic signed [DW-1:0]               last_measured, last_measured_next;
  logic                               first_sample, first_sample_next;
  logic [pidc_pkg::SETTLE_W-1:0]      settle_count, settle_count_next;

  logic f1_adv, f2_fire;

  logic signed [DW-1:0]     sp_wrapped;
  logic signed [WRAP_W-1:0] diff_x;
  logic signed [DW-1:0]     err_c;
  logic signed [CMP_W-1:0]  err_x, band_x, cap_x, dev_x;
  logic signed [DW-1:0]     cap_s;
  err_cls_t                 cls_c;
  logic signed [DW-1:0]     step_c;
  logic                     near_c;

  logic signed [DW-1:0]               base;
  logic signed [DW:0]                 acc33;
  logic signed [DW-1:0]               acc_sat;
  logic signed [DW-1:0]               isum_upd;
  logic signed [DW-1:0]               last_eff;
  logic signed [pidc_pkg::VEL_W-1:0]  vel;
  logic                               done;

  // handshake between stages
  assign f2_fire      = f2_valid && !full;
  assign f1_adv       = f1_valid && (!f2_valid || f2_fire);
  assign sample.ready = !f1_valid || f1_adv;

  // wrap the setpoint on entry
  assign sp_wrapped = sat32(wrap_angle(WRAP_W'(sample.setpoint)));

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      f1_valid <= 1'b1;
    end else if (f1_adv) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      f1_op   <= sample.opcode;
      f1_meas <= sample.measured;
      f1_sp   <= sp_wrapped;
    end
  end

  // wrapped error and its class against the band
  assign diff_x = WRAP_W'(f1_sp) - WRAP_W'(f1_meas);
  assign err_c  = sat32(wrap_angle(diff_x));
  assign err_x  = CMP_W'(err_c);
  assign band_x = $signed({3'b000, cfg.error_band});
  assign cap_x  = $signed({3'b000, cfg.integral_step_cap});
  assign cap_s  = $signed({1'b0, cfg.integral_step_cap});
  assign dev_x  = CMP_W'(f1_meas) - CMP_W'(f1_sp);
  assign near_c = (dev_x <= band_x) && (dev_x >= -band_x);

  always_comb begin
    cls_c  = CLS_ZERO;
    step_c = err_c;
    if (err_x >= band_x) begin
      cls_c  = CLS_POS;
      step_c = (err_x < cap_x) ? err_c : cap_s;
    end else if (err_x <= -band_x) begin
      cls_c  = CLS_NEG;
      step_c = (err_x > -cap_x) ? err_c : -cap_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (f1_adv) begin
      f2_valid <= 1'b1;
    end else if (f2_fire) begin
      f2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_adv) begin
      f2_op   <= f1_op;
      f2_meas <= f1_meas;
      f2_sp   <= f1_sp;
      f2_err  <= err_c;
      f2_step <= step_c;
      f2_cls  <= cls_c;
      f2_near <= near_c;
    end
  end

  // integral with sign-change reset, clear inside the band, capped step and saturation
  always_comb begin
    if (f2_cls == CLS_POS) base = (isum < 0) ? '0 : isum;
    else base = (isum > 0) ? '0 : isum;
  end

  assign acc33   = (DW + 1)'(base) + (DW + 1)'(f2_step);
  assign acc_sat = (acc33[DW] != acc33[DW-1]) ?
                   (acc33[DW] ? S32_MIN[DW-1:0] : S32_MAX[DW-1:0]) : acc33[DW-1:0];
  assign isum_upd = (f2_cls == CLS_ZERO) ? '0 : acc_sat;

  // measured change, zero on the very first sample
  assign last_eff = first_sample ? f2_meas : last_measured;
  assign vel      = pidc_pkg::VEL_W'(f2_meas) - pidc_pkg::VEL_W'(last_eff);
  assign done     = f2_near &&
                    (settle_count >= pidc_pkg::SETTLE_W'(MIN_SETTLE_SAMPLES));

  // state update when the stage 2 beat leaves
  always_comb begin
    isum_next          = isum;
    last_measured_next = last_measured;
    first_sample_next  = first_sample;
    settle_count_next  = settle_count;
    push               = 1'b0;
    if (f2_fire) begin
      unique case (pidc_pkg::opcode_t'(f2_op))
        pidc_pkg::OP_SAMPLE: begin
          push               = 1'b1;
          isum_next          = isum_upd;
          last_measured_next = f2_meas;
          first_sample_next  = 1'b0;
          if (!f2_near) settle_count_next = '0;
          else if (!done) settle_count_next = settle_count + 1'b1;
        end
        pidc_pkg::OP_CLR_INT: begin
          isum_next = '0;
        end
        pidc_pkg::OP_CLR_ALL: begin
          isum_next          = '0;
          last_measured_next = '0;
          settle_count_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      isum          <= '0;
      last_measured <= '0;
      first_sample  <= 1'b1;
      settle_count  <= '0;
    end else begin
      isum          <= isum_next;
      last_measured <= last_measured_next;
      first_sample  <= first_sample_next;
      settle_count  <= settle_count_next;
    end
  end

  // job for the back end
  always_comb begin
    push_job.err  = f2_err;
    push_job.sp   = f2_sp;
    push_job.vel  = vel;
    push_job.isum = isum_upd;
    push_job.done = done;
  end

endmodule

@@ hw/rtl/pidc_queue.sv @@
// ----------------------------------------------------------------------------
// pidc_queue
// Short register queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module pidc_queue #(
  parameter int DEPTH = pidc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pidc_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output pidc_pkg::job_t rd_job,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pidc_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  // entry write
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/pidc_back.sv @@
// ----------------------------------------------------------------------------
// pidc_back
// Takes jobs from the queue: gain products, term sum, clamp and floor,
// then holds the result beat in the output register.
// ----------------------------------------------------------------------------
module pidc_back #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pidc_pkg::job_t pop_job,
  input  logic           empty,
  output logic           pop,
  input  pidc_pkg::cfg_t cfg,
  pidc_result_if.source  result
);

  localparam int DW    = pidc_pkg::DATA_W;
  localparam int PW    = 2 * DW;
  localparam int PDW   = DW + pidc_pkg::VEL_W;
  localparam int SUM_W = PDW + 2;

  // multiply stage
  logic                  m_valid;
  logic signed [PW-1:0]  m_prod_p, m_prod_i, m_prod_ff;
  logic signed [PDW-1:0] m_prod_d;
  logic signed [DW-1:0]  m_err;
  logic                  m_done;

  // sum stage
  logic                    s_valid;
  logic signed [SUM_W-1:0] s_acc;
  logic signed [DW-1:0]    s_err;
  logic                    s_done;

  // output register
  logic                 o_valid;
  logic signed [DW-1:0] o_drive;
  logic signed [DW-1:0] o_err;
  logic                 o_done;

  logic o_ready, s_ready, m_ready, s_adv, m_adv;

  logic signed [SUM_W-1:0] term_p, term_i, term_d, term_ff;
  logic signed [SUM_W-1:0] ceil_x;
  logic signed [DW-1:0]    ceil_s, floor_s, clamped, drive_c;

  // stall chain
  assign o_ready = !o_valid || result.ready;
  assign s_adv   = s_valid && o_ready;
  assign s_ready = !s_valid || o_ready;
  assign m_adv   = m_valid && s_ready;
  assign m_ready = !m_valid || s_ready;
  assign pop     = !empty && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (pop) m_valid <= 1'b1;
      else if (m_adv) m_valid <= 1'b0;
      if (m_adv) s_valid <= 1'b1;
      else if (s_adv) s_valid <= 1'b0;
      if (s_adv) o_valid <= 1'b1;
      else if (result.ready) o_valid <= 1'b0;
    end
  end

  // four gain products
  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod_p  <= cfg.gain_p * pop_job.err;
      m_prod_i  <= cfg.gain_i * pop_job.isum;
      m_prod_d  <= cfg.gain_d * pop_job.vel;
      m_prod_ff <= cfg.gain_ff * pop_job.sp;
      m_err     <= pop_job.err;
      m_done    <= pop_job.done;
    end
  end

  // floor shifts and exact sum
  assign term_p  = SUM_W'(m_prod_p) >>> FRAC_BITS;
  assign term_i  = SUM_W'(m_prod_i) >>> FRAC_BITS;
  assign term_d  = SUM_W'(m_prod_d) >>> FRAC_BITS;
  assign term_ff = SUM_W'(m_prod_ff) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (m_adv) begin
      s_acc  <= term_p + term_i - term_d + term_ff;
      s_err  <= m_err;
      s_done <= m_done;
    end
  end

  // clamp to the ceiling, then push out to the floor
  assign ceil_x  = $signed({{(SUM_W - pidc_pkg::UCFG_W){1'b0}}, cfg.output_ceiling});
  assign ceil_s  = $signed({1'b0, cfg.output_ceiling});
  assign floor_s = $signed({1'b0, cfg.output_floor});

  always_comb begin
    if (s_acc > ceil_x) clamped = ceil_s;
    else if (s_acc < -ceil_x) clamped = -ceil_s;
    else clamped = s_acc[DW-1:0];
    drive_c = clamped;
    if ((clamped < floor_s) && (clamped > -floor_s)) begin
      drive_c = (clamped > 0) ? floor_s : -floor_s;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) begin
      o_drive <= drive_c;
      o_err   <= s_err;
      o_done  <= s_done;
    end
  end

  assign result.valid       = o_valid;
  assign result.drive       = o_drive;
  assign result.error_value = o_err;
  assign result.settled     = o_done;

endmodule

@@ hw/rtl/pid_controller_windup_clamp.sv @@
// ----------------------------------------------------------------------------
// pid_controller_windup_clamp
// PID controller with integral anti-windup, output clamp and settle flag.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: valid/ready beats of opcode, measured and setpoint.
//   Opcode sample gives one result beat; clear-integral and clear-state
//   opcodes, and the unused code, give none.
//   result channel: valid/ready beats of drive, error_value and settled.
//   Configuration: write cfg_data to register cfg_index while cfg_en is high;
//   write only while no sample is in flight.
// Path: a sample accepted on the sample channel passes in order through the
//   two front stages, queue, product stage, sum stage and output register.
// Throughput: one sample per cycle while no stall holds the pipeline; the
//   integral and settle state update per beat in the second front stage.
// Stall: while the result is not taken, the back end and the job queue fill,
//   then the front end holds and sample ready drops.
// Reset: clears the gains, band, ceiling and floor, sets the step cap to 1.0,
//   empties all stages and queue, clears the integral and settle count and
//   marks the next sample as the first.
// ----------------------------------------------------------------------------
module pid_controller_windup_clamp #(
  parameter int ANGLE_MODE         = pidc_pkg::ANGLE_MODE_DEF,
  parameter int MIN_SETTLE_SAMPLES = pidc_pkg::MIN_SETTLE_DEF,
  parameter int FRAC_BITS          = pidc_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH        = pidc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  pidc_sample_if.sink                    sample,
  pidc_result_if.source                  result,
  input  logic                           cfg_en,
  input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]    cfg_data
);

  pidc_pkg::cfg_t cfg;
  pidc_pkg::job_t push_job, rd_job;
  logic           push, pop, full, empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p            <= '0;
      cfg.gain_i            <= '0;
      cfg.gain_d            <= '0;
      cfg.gain_ff           <= '0;
      cfg.error_band        <= '0;
      cfg.integral_step_cap <= pidc_pkg::STEP_CAP_RESET;
      cfg.output_ceiling    <= '0;
      cfg.output_floor      <= '0;
    end else if (cfg_en) begin
      unique case (pidc_pkg::cfg_reg_t'(cfg_index))
        pidc_pkg::REG_GAIN_P:      cfg.gain_p  <= $signed(cfg_data);
        pidc_pkg::REG_GAIN_I:      cfg.gain_i  <= $signed(cfg_data);
        pidc_pkg::REG_GAIN_D:      cfg.gain_d  <= $signed(cfg_data);
        pidc_pkg::REG_GAIN_FF:     cfg.gain_ff <= $signed(cfg_data);
        pidc_pkg::REG_ERROR_BAND:  cfg.error_band <= cfg_data[pidc_pkg::UCFG_W-1:0];
        pidc_pkg::REG_STEP_CAP:    cfg.integral_step_cap <= cfg_data[pidc_pkg::UCFG_W-1:0];
        pidc_pkg::REG_OUT_CEILING: cfg.output_ceiling <= cfg_data[pidc_pkg::UCFG_W-1:0];
        pidc_pkg::REG_OUT_FLOOR:   cfg.output_floor <= cfg_data[pidc_pkg::UCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front end: classify and update state
  pidc_front #(
    .ANGLE_MODE         (ANGLE_MODE),
    .MIN_SETTLE_SAMPLES (MIN_SETTLE_SAMPLES),
    .FRAC_BITS          (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .cfg      (cfg),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  // job queue
  pidc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .full   (full),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (empty)
  );

  // back end: products, sum, clamp
  pidc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .pop_job (rd_job),
    .empty   (empty),
    .pop     (pop),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

@@ hw/rtl/pidc_checker.sv @@
// ----------------------------------------------------------------------------
// pidc_checker
// Port-level assertions for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sample_valid,
  input logic                              sample_ready,
  input logic [1:0]                        sample_opcode,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [pidc_pkg::DATA_W-1:0] result_drive,
  input logic signed [pidc_pkg::DATA_W-1:0] result_error_value,
  input logic                              result_settled
);

  logic [7:0] pending, pending_next;
  logic       inc, dec;

  // samples accepted whose result beat is not yet taken
  assign inc = sample_valid && sample_ready && (sample_opcode == pidc_pkg::OP_SAMPLE);
  assign dec = result_valid && result_ready;

  always_comb begin
    pending_next = pending;
    if (inc && !dec) pending_next = pending + 1'b1;
    else if (dec && !inc) pending_next = pending - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending_next;
  end

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result beat stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  // a stalled result beat keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(result_drive) && $stable(result_error_value) && $stable(result_settled))
    else $error("result payload changed while stalled");

  // every result beat belongs to an accepted sample
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 8'd0)
    else $error("result beat without a pending sample");

endmodule

bind pid_controller_windup_clamp pidc_checker u_pidc_checker (
  .clk                (clk),
  .rst                (rst),
  .sample_valid       (sample.valid),
  .sample_ready       (sample.ready),
  .sample_opcode      (sample.opcode),
  .result_valid       (result.valid),
  .result_ready       (result.ready),
  .result_drive       (result.drive),
  .result_error_value (result.error_value),
  .result_settled     (result.settled)
);

@@ sim/pidc_result_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pidc_result_check
// Watches the sample and result channels of the PID controller, keeps its own
// copy of the controller state and registers, works out the result of every
// sample beat and compares each result beat, field by field, in order.
// ----------------------------------------------------------------------------
module pidc_result_check
  import pidc_pkg::*;
#(
  parameter int ANGLE_MODE         = ANGLE_MODE_DEF,
  parameter int MIN_SETTLE_SAMPLES = MIN_SETTLE_DEF,
  parameter int FRAC_BITS          = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  pidc_sample_if               sample,
  pidc_result_if               result,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0] drive;
    logic [DATA_W-1:0] error_value;
    logic              settled;
  } ctrl_out_t;

  ctrl_out_t ctrl_out_q[$];

  // register copies, widened for exact products
  longint k_p, k_i, k_d, k_ff;
  longint band_w, cap_w, ceil_w, floor_w;

  // controller state
  longint     isum;
  longint     prev_meas;
  bit         first_pending;
  logic [7:0] settle_cnt;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one correction by a full turn, then saturate; no change with no angle mode
  function automatic longint wrap_turn(input longint x);
    longint half_t;
    longint full_t;
    int     s;
    s = 30 - FRAC_BITS;
    if (ANGLE_MODE == ANGLE_DEG) begin
      half_t = longint'(180) <<< FRAC_BITS;
      full_t = longint'(360) <<< FRAC_BITS;
    end else if (ANGLE_MODE == ANGLE_RAD) begin
      half_t = (PI_Q30 + (longint'(1) <<< (s - 1))) >>> s;
      full_t = (TWO_PI_Q30 + (longint'(1) <<< (s - 1))) >>> s;
    end else begin
      return x;
    end
    if (x > half_t) x = x - full_t;
    else if (x < -half_t) x = x + full_t;
    return clip32(x);
  endfunction

  // update the state for one accepted beat and queue its result, if any
  task automatic advance_controller(input logic [1:0] op,
                                    input logic signed [DATA_W-1:0] meas_in,
                                    input logic signed [DATA_W-1:0] sp_in);
    longint    meas, sp, err, step, vel, acc, diff;
    logic      done;
    ctrl_out_t o;
    done = 1'b0;
    case (op)
      OP_CLR_INT: isum = 0;
      OP_CLR_ALL: begin
        isum       = 0;
        prev_meas  = 0;
        settle_cnt = '0;
      end
      OP_SAMPLE: begin
        meas = longint'(meas_in);
        sp   = wrap_turn(longint'(sp_in));
        if (first_pending) begin
          prev_meas     = meas;
          first_pending = 1'b0;
        end
        err = clip32(wrap_turn(sp - meas));

        // anti-windup: clear on sign change or inside the band
        if (err >= band_w) begin
          if (isum < 0) isum = 0;
          step = (err < cap_w) ? err : cap_w;
          isum = clip32(isum + step);
        end else if (err <= -band_w) begin
          if (isum > 0) isum = 0;
          step = (err > -cap_w) ? err : -cap_w;
          isum = clip32(isum + step);
        end else begin
          isum = 0;
        end

        vel = meas - prev_meas;
        acc = ((k_p * err) >>> FRAC_BITS) + ((k_i * isum) >>> FRAC_BITS)
            - ((k_d * vel) >>> FRAC_BITS) + ((k_ff * sp) >>> FRAC_BITS);

        // ceiling clamp, then push out of the dead zone
        if (acc > ceil_w) acc = ceil_w;
        else if (acc < -ceil_w) acc = -ceil_w;
        if (acc < floor_w && acc > -floor_w) acc = (acc > 0) ? floor_w : -floor_w;

        prev_meas = meas;

        diff = meas - sp;
        if (diff <= band_w && diff >= -band_w) begin
          if (settle_cnt >= MIN_SETTLE_SAMPLES) done = 1'b1;
          else settle_cnt = settle_cnt + 8'd1;
        end else begin
          settle_cnt = '0;
        end

        o.drive       = acc[DATA_W-1:0];
        o.error_value = err[DATA_W-1:0];
        o.settled     = done;
        ctrl_out_q.push_back(o);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    ctrl_out_t exp_out;
    if (rst) begin
      k_p           = 0;
      k_i           = 0;
      k_d           = 0;
      k_ff          = 0;
      band_w        = 0;
      cap_w         = longint'(STEP_CAP_RESET);
      ceil_w        = 0;
      floor_w       = 0;
      isum          = 0;
      prev_meas     = 0;
      first_pending = 1'b1;
      settle_cnt    = '0;
      mismatches    = 0;
      ctrl_out_q.delete();
    end else begin
      // result beat against the oldest expectation
      if (result.valid && result.ready) begin
        if (ctrl_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: drive %h error %h settled %b",
                     $time, result.drive, result.error_value, result.settled);
        end else begin
          exp_out = ctrl_out_q.pop_front();
          if (result.drive !== exp_out.drive || result.error_value !== exp_out.error_value
              || result.settled !== exp_out.settled) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: drive exp %h got %h, error exp %h got %h, settled exp %b got %b",
                       $time, exp_out.drive, result.drive, exp_out.error_value,
                       result.error_value, exp_out.settled, result.settled);
          end
        end
      end

      // register writes
      if (cfg_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_GAIN_P:      k_p     = longint'($signed(cfg_data));
          REG_GAIN_I:      k_i     = longint'($signed(cfg_data));
          REG_GAIN_D:      k_d     = longint'($signed(cfg_data));
          REG_GAIN_FF:     k_ff    = longint'($signed(cfg_data));
          REG_ERROR_BAND:  band_w  = longint'(cfg_data[UCFG_W-1:0]);
          REG_STEP_CAP:    cap_w   = longint'(cfg_data[UCFG_W-1:0]);
          REG_OUT_CEILING: ceil_w  = longint'(cfg_data[UCFG_W-1:0]);
          REG_OUT_FLOOR:   floor_w = longint'(cfg_data[UCFG_W-1:0]);
          default: ;
        endcase
      end

      // sample beat
      if (sample.valid && sample.ready)
        advance_controller(sample.opcode, sample.measured, sample.setpoint);
    end
    outstanding <= ctrl_out_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the PID controller: a directed run over the field extremes,
// the clear opcodes and the band edges, then phases of tracking sequences and
// noise under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import pidc_pkg::*;

  localparam int         ANGLE_MODE   = ANGLE_MODE_DEF;
  localparam int         MIN_SETTLE   = MIN_SETTLE_DEF;
  localparam int         FRAC_BITS    = FRAC_BITS_DEF;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         PHASE_ITEMS  = 138;

  logic                 clk;
  logic                 rst;
  logic                 cfg_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   quiet_cycles   = 0;
  int   mismatches;
  int   outstanding;
  cfg_t phase_cfg;

  pidc_sample_if sample_ch ();
  pidc_result_if result_ch ();

  pid_controller_windup_clamp #(
    .ANGLE_MODE        (ANGLE_MODE),
    .MIN_SETTLE_SAMPLES(MIN_SETTLE),
    .FRAC_BITS         (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (result_ch),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pidc_result_check #(
    .ANGLE_MODE        (ANGLE_MODE),
    .MIN_SETTLE_SAMPLES(MIN_SETTLE),
    .FRAC_BITS         (FRAC_BITS)
  ) rcheck (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .result     (result_ch),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side stalls
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst || cfg_en || (sample_ch.valid && sample_ch.ready)
        || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // random Q16.16 value: full range, extremes, small or scaled down
  function automatic logic [DATA_W-1:0] rand_q16();
    case ($urandom_range(5))
      0: return $urandom;
      1: case ($urandom_range(2))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           default: return 32'h0000_0000;
         endcase
      2, 3: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: return $signed($urandom) >>> $urandom_range(0, 16);
    endcase
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
      3: begin src_idle_pct = 12; sink_stall_pct = 12; end
      default: begin src_idle_pct = 0; sink_stall_pct = 0; end
    endcase
  endtask

  // write all registers back to back; unsigned ones may carry a stray top bit
  task automatic apply_config(input cfg_t c, input bit rand_top);
    logic [DATA_W-1:0] word;
    logic              top;
    int                k;
    phase_cfg = c;
    for (k = 0; k < 8; k++) begin
      top = rand_top ? 1'($urandom_range(1)) : 1'b0;
      case (cfg_reg_t'(k))
        REG_GAIN_P:      word = c.gain_p;
        REG_GAIN_I:      word = c.gain_i;
        REG_GAIN_D:      word = c.gain_d;
        REG_GAIN_FF:     word = c.gain_ff;
        REG_ERROR_BAND:  word = {top, c.error_band};
        REG_STEP_CAP:    word = {top, c.integral_step_cap};
        REG_OUT_CEILING: word = {top, c.output_ceiling};
        default:         word = {top, c.output_floor};
      endcase
      cfg_en    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= word;
      @(posedge clk);
    end
    cfg_en <= 1'b0;
  endtask

  // one sample beat, with a random gap before it
  task automatic push_sample(input logic [1:0] op, input logic [DATA_W-1:0] meas,
                             input logic [DATA_W-1:0] sp);
    if ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.opcode   <= op;
    sample_ch.measured <= meas;
    sample_ch.setpoint <= sp;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // wait for every expected result, then for the no-result beats in flight
  task automatic drain_pipeline();
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // tracking runs around a setpoint, mixed with noise and clear opcodes
  task automatic run_phase(input int count);
    int                made;
    int                run_len;
    int                r;
    int                pick;
    longint            base;
    longint            band;
    longint            off;
    longint            meas;
    logic [DATA_W-1:0] sp;
    made = 0;
    band = longint'(phase_cfg.error_band);
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        push_sample($urandom_range(1) ? OP_CLR_INT : OP_CLR_ALL, $urandom, $urandom);
        made++;
      end else if (pick < 9) begin
        push_sample(OP_UNUSED, $urandom, $urandom);
      end else if (pick < 30) begin
        push_sample(OP_SAMPLE, rand_q16(), rand_q16());
        made++;
      end else begin
        sp      = rand_q16();
        base    = longint'($signed(sp));
        run_len = $urandom_range(1, 16);
        for (r = 0; r < run_len && made < count; r++) begin
          case ($urandom_range(19))
            0: off = band + 1 + $urandom_range(0, 32'hFFFF);
            1: off = band;
            2: off = -band;
            default: off = longint'($urandom_range(0, 32'(2 * band))) - band;
          endcase
          meas = base + off;
          if (meas > 64'sd2147483647) meas = 64'sd2147483647;
          if (meas < -64'sd2147483648) meas = -64'sd2147483648;
          push_sample(OP_SAMPLE, meas[DATA_W-1:0], sp);
          made++;
        end
      end
    end
  endtask

  initial begin
    cfg_t c;
    int   k;
    int   i;
    rst                <= 1'b1;
    cfg_en             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.opcode   <= OP_SAMPLE;
    sample_ch.measured <= '0;
    sample_ch.setpoint <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: modest gains, band 1.0, cap 2.0, ceiling 1000.0
    c.gain_p            = 32'h0001_0000;
    c.gain_i            = 32'h0000_8000;
    c.gain_d            = 32'h0000_4000;
    c.gain_ff           = 32'h0000_2000;
    c.error_band        = 31'h0001_0000;
    c.integral_step_cap = 31'h0002_0000;
    c.output_ceiling    = 31'h03E8_0000;
    c.output_floor      = 31'd655;
    apply_config(c, 1'b0);

    // unused code before the first sample, then the first sample
    push_sample(OP_UNUSED, 32'h1234_5678, 32'h8765_4321);
    push_sample(OP_SAMPLE, 32'h0005_0000, 32'h0003_0000);
    // error saturation both ways, with a sign change between
    push_sample(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
    // error exactly on the band edges, then inside the band
    push_sample(OP_SAMPLE, 32'h0000_0000, 32'h0001_0000);
    push_sample(OP_SAMPLE, 32'h0001_0000, 32'h0000_0000);
    push_sample(OP_SAMPLE, 32'h0000_0000, 32'h0000_8000);
    // step cap on a large error, integral clear, then again
    push_sample(OP_SAMPLE, 32'h0000_0000, 32'h0050_0000);
    push_sample(OP_CLR_INT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_sample(OP_SAMPLE, 32'h0000_0000, 32'h0050_0000);
    // full clear, then a zero drive pushed out to minus floor
    push_sample(OP_CLR_ALL, 32'h0000_0000, 32'h0000_0000);
    push_sample(OP_SAMPLE, 32'h0000_0000, 32'h0000_0000);
    // enough in-band samples to raise the settled flag
    for (i = 0; i < 12; i++)
      push_sample(OP_SAMPLE, 32'h0003_0000 + 32'(i) * 32'h1000, 32'h0003_0000);
    push_sample(OP_SAMPLE, 32'h0100_0000, 32'h0000_0000);
    sample_ch.valid <= 1'b0;

    // random phases under changing settings and idling
    for (k = 1; k <= 6; k++) begin
      drain_pipeline();
      set_idling(k % 4);
      case (k)
        1: begin
          c.gain_p            = 32'h7FFF_FFFF;
          c.gain_i            = 32'h7FFF_FFFF;
          c.gain_d            = 32'h7FFF_FFFF;
          c.gain_ff           = 32'h7FFF_FFFF;
          c.error_band        = '0;
          c.integral_step_cap = 31'h7FFF_FFFF;
          c.output_ceiling    = 31'h7FFF_FFFF;
          c.output_floor      = '0;
        end
        2: begin
          c.gain_p            = 32'h8000_0000;
          c.gain_i            = 32'h8000_0000;
          c.gain_d            = 32'h8000_0000;
          c.gain_ff           = 32'h8000_0000;
          c.error_band        = 31'h7FFF_FFFF;
          c.integral_step_cap = '0;
          c.output_ceiling    = '0;
          c.output_floor      = '0;
        end
        3: begin
          // floor above the ceiling
          c.gain_p            = $urandom;
          c.gain_i            = $urandom;
          c.gain_d            = $urandom;
          c.gain_ff           = $urandom;
          c.error_band        = 31'($urandom_range(0, 32'h0004_0000));
          c.integral_step_cap = 31'($urandom);
          c.output_ceiling    = 31'h0064_0000;
          c.output_floor      = 31'h00C8_0000;
        end
        default: begin
          c.gain_p            = $urandom;
          c.gain_i            = $urandom;
          c.gain_d            = $urandom;
          c.gain_ff           = $urandom;
          c.error_band        = 31'($urandom_range(0, 32'h0010_0000));
          c.integral_step_cap = 31'($urandom);
          c.output_ceiling    = 31'($urandom);
          c.output_floor      = 31'($urandom_range(0, 32'hFFFF));
        end
      endcase
      apply_config(c, k >= 4);
      run_phase(PHASE_ITEMS);
      sample_ch.valid <= 1'b0;
    end

    drain_pipeline();
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
